@@ hdl/lwf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types and constants of the lidar wall follow controller: motion
// modes, case codes, register indexes, sector bounds and the structs that
// pass between the scan datapath and the decision logic.
// ----------------------------------------------------------------------------
package lwf_pkg;

	// Points per scan; the sector bounds below assume this value
	localparam int SCAN_POINTS = 360;

	// Field widths
	localparam int RANGE_IN_W = 16;
	localparam int INDEX_W    = 9;
	localparam int LIMIT_W    = 14;
	localparam int SPEED_W    = 10;
	localparam int TURN_W     = 11;
	localparam int CASE_W     = 4;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// Speed commands saturate here
	localparam logic [SPEED_W-1:0] SPEED_CAP = 10'd1000;

	// Sector bounds, inclusive
	localparam logic [INDEX_W-1:0] FRONT_A_HI = 9'd21;
	localparam logic [INDEX_W-1:0] FRONT_B_LO = 9'd338;
	localparam logic [INDEX_W-1:0] FRONT_B_HI = 9'd358;
	localparam logic [INDEX_W-1:0] LEFT_LO    = 9'd23;
	localparam logic [INDEX_W-1:0] LEFT_HI    = 9'd52;
	localparam logic [INDEX_W-1:0] RIGHT_LO   = 9'd306;
	localparam logic [INDEX_W-1:0] RIGHT_HI   = 9'd336;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_ENABLE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NEAR_LIMIT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIAG_LIMIT   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TURN_SPEED   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DIAG_INDEX   = 3'd5;

	// Configuration reset values
	localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST   = 14'd300;
	localparam logic [LIMIT_W-1:0] DIAG_LIMIT_RST   = 14'd400;
	localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = 10'd150;
	localparam logic [SPEED_W-1:0] TURN_SPEED_RST   = 10'd300;
	localparam logic [INDEX_W-1:0] DIAG_INDEX_RST   = 9'd45;

	// Decision case codes
	localparam logic [CASE_W-1:0] CASE_NONE             = 4'd0;
	localparam logic [CASE_W-1:0] CASE_FRONT_ONLY       = 4'd1;
	localparam logic [CASE_W-1:0] CASE_RIGHT_ONLY       = 4'd2;
	localparam logic [CASE_W-1:0] CASE_ALL_OPEN_DIAG    = 4'd3;
	localparam logic [CASE_W-1:0] CASE_LEFT_ONLY        = 4'd4;
	localparam logic [CASE_W-1:0] CASE_FRONT_RIGHT      = 4'd5;
	localparam logic [CASE_W-1:0] CASE_FRONT_LEFT       = 4'd6;
	localparam logic [CASE_W-1:0] CASE_ALL_BLOCKED      = 4'd7;
	localparam logic [CASE_W-1:0] CASE_LEFT_RIGHT       = 4'd8;

	typedef enum logic [1:0] {
		MODE_FIND_WALL   = 2'd0,
		MODE_TURN_LEFT   = 2'd1,
		MODE_FOLLOW_WALL = 2'd2,
		MODE_TURN_RIGHT  = 2'd3
	} lwf_mode_t;

	// Strict comparisons of the sector minima against the limits
	typedef struct packed {
		logic front_blocked;
		logic front_open;
		logic left_blocked;
		logic left_open;
		logic right_blocked;
		logic right_open;
		logic diag_open;
	} lwf_flags_t;

	// Decision outcome
	typedef struct packed {
		lwf_mode_t                 mode;
		logic [SPEED_W-1:0]        forward_speed;
		logic signed [TURN_W-1:0]  turn_rate;
		logic [CASE_W-1:0]         matched_case;
	} lwf_cmd_t;

endpackage

@@ hdl/lwf_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwf_decide
// Picks the motion mode from the sector comparison flags and builds the
// drive command for that mode, with speeds saturated to the cap.
// ----------------------------------------------------------------------------
module lwf_decide (
	input  lwf_pkg::lwf_flags_t               flags,
	input  lwf_pkg::lwf_mode_t                cur_mode,
	input  logic [lwf_pkg::SPEED_W-1:0]       cruise_speed,
	input  logic [lwf_pkg::SPEED_W-1:0]       turn_speed,
	output lwf_pkg::lwf_cmd_t                 cmd
);

	logic [lwf_pkg::SPEED_W-1:0] cruise_sat;
	logic [lwf_pkg::SPEED_W-1:0] turn_sat;
	lwf_pkg::lwf_mode_t          next_mode;
	logic [lwf_pkg::CASE_W-1:0]  hit_case;

	// Saturate speed registers
	assign cruise_sat = (cruise_speed > lwf_pkg::SPEED_CAP) ? lwf_pkg::SPEED_CAP : cruise_speed;
	assign turn_sat   = (turn_speed > lwf_pkg::SPEED_CAP) ? lwf_pkg::SPEED_CAP : turn_speed;

	// Ordered case table; no match keeps the current mode
	always_comb begin
		next_mode = cur_mode;
		hit_case  = lwf_pkg::CASE_NONE;
		if (flags.front_blocked && flags.left_open && flags.right_open) begin
			next_mode = lwf_pkg::MODE_TURN_RIGHT;
			hit_case  = lwf_pkg::CASE_FRONT_ONLY;
		end else if (flags.front_open && flags.left_open && flags.right_blocked) begin
			next_mode = lwf_pkg::MODE_FOLLOW_WALL;
			hit_case  = lwf_pkg::CASE_RIGHT_ONLY;
		end else if (flags.front_open && flags.left_open && flags.right_open &&
				flags.diag_open) begin
			next_mode = lwf_pkg::MODE_TURN_LEFT;
			hit_case  = lwf_pkg::CASE_ALL_OPEN_DIAG;
		end else if (flags.front_open && flags.left_blocked && flags.right_open) begin
			next_mode = lwf_pkg::MODE_FOLLOW_WALL;
			hit_case  = lwf_pkg::CASE_LEFT_ONLY;
		end else if (flags.front_blocked && flags.left_open && flags.right_blocked) begin
			next_mode = lwf_pkg::MODE_TURN_RIGHT;
			hit_case  = lwf_pkg::CASE_FRONT_RIGHT;
		end else if (flags.front_blocked && flags.left_blocked && flags.right_open) begin
			next_mode = lwf_pkg::MODE_TURN_RIGHT;
			hit_case  = lwf_pkg::CASE_FRONT_LEFT;
		end else if (flags.front_blocked && flags.left_blocked && flags.right_blocked) begin
			next_mode = lwf_pkg::MODE_TURN_RIGHT;
			hit_case  = lwf_pkg::CASE_ALL_BLOCKED;
		end else if (flags.front_open && flags.left_blocked && flags.right_blocked) begin
			next_mode = lwf_pkg::MODE_FIND_WALL;
			hit_case  = lwf_pkg::CASE_LEFT_RIGHT;
		end
	end

	// Drive command for the chosen mode
	always_comb begin
		cmd.mode          = next_mode;
		cmd.matched_case  = hit_case;
		cmd.forward_speed = '0;
		cmd.turn_rate     = '0;
		case (next_mode)
			lwf_pkg::MODE_FIND_WALL,
			lwf_pkg::MODE_FOLLOW_WALL: begin
				cmd.forward_speed = cruise_sat;
			end
			lwf_pkg::MODE_TURN_LEFT: begin
				cmd.turn_rate = $signed({1'b0, turn_sat});
			end
			lwf_pkg::MODE_TURN_RIGHT: begin
				cmd.turn_rate = -$signed({1'b0, turn_sat});
			end
			default: begin
				cmd.forward_speed = '0;
			end
		endcase
	end

endmodule

@@ hdl/lidar_wall_follow_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_wall_follow_controller
// Result path: a scan-end sample passes through the input register, then the result register.
// Throughput: one sample per cycle; the input register stalls only when it
//   holds a scan end and the result register is still occupied.
// Reset: asynchronous, active low; clears handshakes, restores the default
//   registers, sets all minima to the max range and the mode to find wall.
//
// Streams range samples, keeps front, front-left and front-right minima and
// one diagonal sample per scan, and on each scan end emits the motion mode
// and drive command chosen by the wall follow case table.
// ----------------------------------------------------------------------------
module lidar_wall_follow_controller #(
	parameter int MAX_RANGE_MM = 10000
) (
	input  logic        clk,
	input  logic        arst_n,
	// Sample stream; tdata: range_mm[15:0], sample_index[24:16], zero pad
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,      // scan_end
	// Result stream; tdata: motion_mode[1:0], forward_speed[11:2],
	// turn_rate[22:12], matched_case[26:23], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tuser,      // drive_valid
	// Configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lwf_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [lwf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int RW    = $clog2(MAX_RANGE_MM + 1);
	localparam int CMP_W = (RW > lwf_pkg::LIMIT_W) ? RW : lwf_pkg::LIMIT_W;
	localparam logic [RW-1:0] RANGE_MAX = RW'(MAX_RANGE_MM);
	localparam logic [lwf_pkg::RANGE_IN_W-1:0] RANGE_MAX_IN =
		lwf_pkg::RANGE_IN_W'(MAX_RANGE_MM);

	// Configuration registers
	logic                            drive_enable_q;
	logic [lwf_pkg::LIMIT_W-1:0]     near_limit_q;
	logic [lwf_pkg::LIMIT_W-1:0]     diag_limit_q;
	logic [lwf_pkg::SPEED_W-1:0]     cruise_speed_q;
	logic [lwf_pkg::SPEED_W-1:0]     turn_speed_q;
	logic [lwf_pkg::INDEX_W-1:0]     diag_index_q;

	// Input register
	logic                              valid_s1;
	logic [lwf_pkg::RANGE_IN_W-1:0]    range_s1;
	logic [lwf_pkg::INDEX_W-1:0]       index_s1;
	logic                              last_s1;

	// Scan state
	logic [RW-1:0]       front_min_q;
	logic [RW-1:0]       left_min_q;
	logic [RW-1:0]       right_min_q;
	logic [RW-1:0]       diag_range_q;
	lwf_pkg::lwf_mode_t  mode_q;

	// Result register
	logic                m_valid_q;
	lwf_pkg::lwf_cmd_t   cmd_q;
	logic                drive_valid_q;

	logic                out_free;
	logic                adv_s1;
	logic [RW-1:0]       range_clamp;
	logic                in_front;
	logic                in_left;
	logic                in_right;
	logic [RW-1:0]       front_nxt;
	logic [RW-1:0]       left_nxt;
	logic [RW-1:0]       right_nxt;
	logic [RW-1:0]       diag_nxt;
	logic [CMP_W-1:0]    near_x;
	logic [CMP_W-1:0]    diag_lim_x;
	lwf_pkg::lwf_flags_t flags;
	lwf_pkg::lwf_cmd_t   cmd;

	// Handshakes
	assign out_free  = !m_valid_q || m_tready;
	assign adv_s1    = valid_s1 && (!last_s1 || out_free);
	assign s_tready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	// Configuration writes; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_enable_q <= 1'b0;
			near_limit_q   <= lwf_pkg::NEAR_LIMIT_RST;
			diag_limit_q   <= lwf_pkg::DIAG_LIMIT_RST;
			cruise_speed_q <= lwf_pkg::CRUISE_SPEED_RST;
			turn_speed_q   <= lwf_pkg::TURN_SPEED_RST;
			diag_index_q   <= lwf_pkg::DIAG_INDEX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lwf_pkg::REG_DRIVE_ENABLE: drive_enable_q <= cfg_data[0];
				lwf_pkg::REG_NEAR_LIMIT:   near_limit_q   <= cfg_data[lwf_pkg::LIMIT_W-1:0];
				lwf_pkg::REG_DIAG_LIMIT:   diag_limit_q   <= cfg_data[lwf_pkg::LIMIT_W-1:0];
				lwf_pkg::REG_CRUISE_SPEED: cruise_speed_q <= cfg_data[lwf_pkg::SPEED_W-1:0];
				lwf_pkg::REG_TURN_SPEED:   turn_speed_q   <= cfg_data[lwf_pkg::SPEED_W-1:0];
				lwf_pkg::REG_DIAG_INDEX:   diag_index_q   <= cfg_data[lwf_pkg::INDEX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			range_s1 <= s_tdata[15:0];
			index_s1 <= s_tdata[24:16];
			last_s1  <= s_tlast;
		end
	end

	// Clamp and sector decode
	assign range_clamp = (range_s1 > RANGE_MAX_IN) ? RANGE_MAX : RW'(range_s1);
	assign in_front = (index_s1 <= lwf_pkg::FRONT_A_HI) ||
		((index_s1 >= lwf_pkg::FRONT_B_LO) && (index_s1 <= lwf_pkg::FRONT_B_HI));
	assign in_left  = (index_s1 >= lwf_pkg::LEFT_LO) && (index_s1 <= lwf_pkg::LEFT_HI);
	assign in_right = (index_s1 >= lwf_pkg::RIGHT_LO) && (index_s1 <= lwf_pkg::RIGHT_HI);

	// Fold the current sample into the running minima
	assign front_nxt = (in_front && (range_clamp < front_min_q)) ? range_clamp : front_min_q;
	assign left_nxt  = (in_left && (range_clamp < left_min_q)) ? range_clamp : left_min_q;
	assign right_nxt = (in_right && (range_clamp < right_min_q)) ? range_clamp : right_min_q;
	assign diag_nxt  = (index_s1 == diag_index_q) ? range_clamp : diag_range_q;

	// Strict compares on the folded values
	assign near_x     = CMP_W'(near_limit_q);
	assign diag_lim_x = CMP_W'(diag_limit_q);
	assign flags.front_blocked = CMP_W'(front_nxt) < near_x;
	assign flags.front_open    = CMP_W'(front_nxt) > near_x;
	assign flags.left_blocked  = CMP_W'(left_nxt) < near_x;
	assign flags.left_open     = CMP_W'(left_nxt) > near_x;
	assign flags.right_blocked = CMP_W'(right_nxt) < near_x;
	assign flags.right_open    = CMP_W'(right_nxt) > near_x;
	assign flags.diag_open     = CMP_W'(diag_nxt) > diag_lim_x;

	lwf_decide u_decide (
		.flags        (flags),
		.cur_mode     (mode_q),
		.cruise_speed (cruise_speed_q),
		.turn_speed   (turn_speed_q),
		.cmd          (cmd)
	);

	// Scan state; restart after a scan end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_min_q  <= RANGE_MAX;
			left_min_q   <= RANGE_MAX;
			right_min_q  <= RANGE_MAX;
			diag_range_q <= RANGE_MAX;
			mode_q       <= lwf_pkg::MODE_FIND_WALL;
		end else if (adv_s1) begin
			if (last_s1) begin
				front_min_q  <= RANGE_MAX;
				left_min_q   <= RANGE_MAX;
				right_min_q  <= RANGE_MAX;
				diag_range_q <= RANGE_MAX;
				mode_q       <= cmd.mode;
			end else begin
				front_min_q  <= front_nxt;
				left_min_q   <= left_nxt;
				right_min_q  <= right_nxt;
				diag_range_q <= diag_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			cmd_q         <= cmd;
			drive_valid_q <= drive_enable_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = drive_valid_q;
	assign m_tdata  = {5'd0, cmd_q.matched_case, cmd_q.turn_rate,
		cmd_q.forward_speed, cmd_q.mode};

	// A new result only comes from a scan end leaving the input register
	a_result_from_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a scan end");

	// Input stalls only behind a blocked scan end
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && m_valid_q && !m_tready))
		else $error("input stalled without a pending scan end");

	// Minima restart after a scan end
	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (front_min_q == RANGE_MAX && left_min_q == RANGE_MAX &&
			right_min_q == RANGE_MAX && diag_range_q == RANGE_MAX))
		else $error("scan state not restarted");

	// Never drive forward and turn at once
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (cmd_q.forward_speed == '0 || cmd_q.turn_rate == '0))
		else $error("forward speed and turn rate both set");

	// Stored mode matches the last reported mode
	a_mode_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (cmd_q.mode == mode_q))
		else $error("reported mode differs from stored mode");

endmodule
